/* design/vdb_pkg.sv */
// ----------------------------------------------------------------------------
// vdb_pkg
// Shared types and constants of the distance and bearing pipeline: CORDIC
// datapath widths, the arctangent step table and the bearing case codes.
// ----------------------------------------------------------------------------
package vdb_pkg;

    // cordic datapath
    localparam int CORDIC_STEPS = 28;
    localparam int CX_W         = 64;
    localparam int CX_TOP       = 60;
    localparam int Z_W          = 33;
    localparam int Z_FRAC       = 24;

    // angle constants in degrees
    localparam int DEG_RIGHT = 90;
    localparam int DEG_HALF  = 180;

    // clamp limit and fold point of the accumulated angle
    localparam logic signed [Z_W-1:0] Z_90  = Z_W'(DEG_RIGHT) <<< Z_FRAC;
    localparam logic [31:0]           Z_180 = 32'(DEG_HALF) << Z_FRAC;

    // atan(2^-i) in 2^-24 degree, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7
    };

    // how the bearing is formed
    typedef enum logic [1:0] {
        BC_ROTATE,
        BC_UP,
        BC_DOWN,
        BC_BACK
    } bear_case_t;

    // control that travels beside the datapath
    typedef struct packed {
        bear_case_t bc;
        logic       dx_neg;
        logic       dy_neg;
    } bear_ctl_t;

endpackage

/* design/vdb_cordic_cell.sv */
// ----------------------------------------------------------------------------
// vdb_cordic_cell
// One vectoring micro-rotation of the CORDIC chain, registered at its output.
// ----------------------------------------------------------------------------
module vdb_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                             clk,
    input  logic [vdb_pkg::CX_W-1:0]         x_in,
    input  logic signed [vdb_pkg::CX_W-1:0]  y_in,
    input  logic signed [vdb_pkg::Z_W-1:0]   z_in,
    output logic [vdb_pkg::CX_W-1:0]         x_out,
    output logic signed [vdb_pkg::CX_W-1:0]  y_out,
    output logic signed [vdb_pkg::Z_W-1:0]   z_out
);
    import vdb_pkg::*;

    localparam logic signed [Z_W-1:0] STEP_ANGLE = ATAN_TAB[STEP];

    logic [CX_W-1:0]        xs;
    logic signed [CX_W-1:0] ys;
    logic [CX_W-1:0]        x_next, x_reg;
    logic signed [CX_W-1:0] y_next, y_reg;
    logic signed [Z_W-1:0]  z_next, z_reg;

    // rotate toward the x axis by the sign of y
    always_comb
    begin
        xs = x_in >> STEP;
        ys = y_in >>> STEP;
        if (!y_in[CX_W-1])
        begin
            x_next = x_in + $unsigned(ys);
            y_next = y_in - $signed(xs);
            z_next = z_in + STEP_ANGLE;
        end
        else
        begin
            x_next = x_in - $unsigned(ys);
            y_next = y_in + $signed(xs);
            z_next = z_in - STEP_ANGLE;
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* design/vdb_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// vdb_sqrt_cell
// One digit of a restoring integer square root, registered at its output.
// ----------------------------------------------------------------------------
module vdb_sqrt_cell #(
    parameter int AW = 17
) (
    input  logic              clk,
    input  logic [2*AW-1:0]   rad_in,
    input  logic [AW+1:0]     rem_in,
    input  logic [AW-1:0]     q_in,
    output logic [2*AW-1:0]   rad_out,
    output logic [AW+1:0]     rem_out,
    output logic [AW-1:0]     q_out
);
    localparam int RW = AW + 2;
    localparam int TW = AW + 4;

    logic [TW-1:0]   acc;
    logic [TW-1:0]   trial;
    logic [2*AW-1:0] rad_next, rad_reg;
    logic [RW-1:0]   rem_next, rem_reg;
    logic [AW-1:0]   q_next, q_reg;

    // bring down two radicand bits and try the next root bit
    always_comb
    begin
        acc      = {rem_in, rad_in[2*AW-1 -: 2]};
        trial    = {2'b00, q_in, 2'b01};
        rad_next = {rad_in[2*AW-3:0], 2'b00};
        if (acc >= trial)
        begin
            rem_next = RW'(acc - trial);
            q_next   = {q_in[AW-2:0], 1'b1};
        end
        else
        begin
            rem_next = acc[RW-1:0];
            q_next   = {q_in[AW-2:0], 1'b0};
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign rad_out = rad_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

/* design/vector_distance_and_bearing_top.sv */
// ----------------------------------------------------------------------------
// vector_distance_and_bearing_top
// Distance and bearing from a start point to an end point: a chain of CORDIC
// vectoring cells for the angle beside a chain of square-root digit cells.
// ----------------------------------------------------------------------------
//  channel   handshake       payload
//  input     start / busy    start_x, start_y, end_x, end_y
//  result    done (strobe)   distance, bearing
//
//  One transaction is taken every clock cycle; busy is always low.
//  Data pass the difference and magnitude stages, the 28-cell CORDIC chain
//  or the root digit chain, whichever is longer, then the fold and output stages.
//  done is high for one cycle per transaction, results leave in input order.
//  rst_n clears only the valid bits of the pipeline; the receiver cannot stall.
// ----------------------------------------------------------------------------
module vector_distance_and_bearing_top #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_WIDTH-1:0]      start_x,
    input  logic signed [COORD_WIDTH-1:0]      start_y,
    input  logic signed [COORD_WIDTH-1:0]      end_x,
    input  logic signed [COORD_WIDTH-1:0]      end_y,
    output logic                               done,
    output logic [COORD_WIDTH:0]               distance,
    output logic signed [ANGLE_FRAC_BITS+8:0]  bearing
);
    import vdb_pkg::*;

    localparam int AW  = COORD_WIDTH + 1;
    localparam int RW  = AW + 2;
    localparam int BW  = ANGLE_FRAC_BITS + 9;
    localparam int SH  = CX_TOP - COORD_WIDTH;
    localparam int CI  = CORDIC_STEPS;
    localparam int SL  = AW + 1;
    localparam int LAT = (CI > SL) ? CI : SL;
    localparam int PC  = LAT - CI;
    localparam int PS  = LAT - SL;
    localparam int RS  = Z_FRAC - ANGLE_FRAC_BITS;

    localparam logic [32:0]          HALF   = 33'(1) << (RS - 1);
    localparam logic signed [BW-1:0] B_UP   = BW'(DEG_RIGHT << ANGLE_FRAC_BITS);
    localparam logic signed [BW-1:0] B_DOWN = -B_UP;
    localparam logic signed [BW-1:0] B_BACK = BW'(DEG_HALF << ANGLE_FRAC_BITS);

    logic accept;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [AW-1:0] dx_next, dx_reg;
    logic signed [AW-1:0] dy_next, dy_reg;

    // stage 2: magnitudes, squares, case
    logic                v2_reg;
    logic [AW-1:0]       a_next, a_reg;
    logic [AW-1:0]       b_next, b_reg;
    logic [2*AW-1:0]     sa_next, sa_reg;
    logic [2*AW-1:0]     sb_next, sb_reg;
    bear_ctl_t           ctl_next, ctl_reg;

    // root radicand
    logic [2*AW-1:0]     sum_reg;

    // cell chains
    logic [CX_W-1:0]        cx [0:CI-1];
    logic signed [CX_W-1:0] cy [0:CI-1];
    logic signed [Z_W-1:0]  cz [0:CI];
    logic [2*AW-1:0]        sr_rad [0:AW-1];
    logic [RW-1:0]          sr_rem [0:AW];
    logic [AW-1:0]          sr_q   [0:AW];

    // aligned chain outputs
    logic signed [Z_W-1:0]  z_lat;
    logic [RW-1:0]          r_lat;
    logic [AW-1:0]          q_lat;

    // control shift line
    logic                   ln_v_reg   [0:LAT-1];
    bear_ctl_t              ln_ctl_reg [0:LAT-1];

    // fold stage
    logic                   fv_reg;
    bear_ctl_t              fctl_reg;
    logic signed [Z_W-1:0]  zc;
    logic [31:0]            m_next, m_reg;
    logic                   up_next, up_reg;
    logic [AW-1:0]          fq_reg;

    // output stage
    logic [32:0]            rnd;
    logic signed [BW-1:0]   mag;
    logic                   done_reg;
    logic [AW-1:0]          dist_next, dist_reg;
    logic signed [BW-1:0]   bear_next, bear_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // coordinate differences
    always_comb
    begin
        dx_next = AW'(end_x) - AW'(start_x);
        dy_next = AW'(end_y) - AW'(start_y);
    end

    // magnitudes, squares and bearing case
    always_comb
    begin
        a_next  = dx_reg[AW-1] ? $unsigned(-dx_reg) : $unsigned(dx_reg);
        b_next  = dy_reg[AW-1] ? $unsigned(-dy_reg) : $unsigned(dy_reg);
        sa_next = (2*AW)'(a_next) * (2*AW)'(a_next);
        sb_next = (2*AW)'(b_next) * (2*AW)'(b_next);
        ctl_next.dx_neg = dx_reg[AW-1];
        ctl_next.dy_neg = dy_reg[AW-1];
        if (dx_reg == '0)
            ctl_next.bc = (!dy_reg[AW-1] && dy_reg != '0) ? BC_UP : BC_DOWN;
        else if (dx_reg[AW-1] && dy_reg == '0)
            ctl_next.bc = BC_BACK;
        else
            ctl_next.bc = BC_ROTATE;
    end

    // front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // front stage payload
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        ctl_reg <= ctl_next;
        sum_reg <= sa_reg + sb_reg;
    end

    // cordic chain on the first-quadrant vector
    assign cx[0] = CX_W'(a_reg) << SH;
    assign cy[0] = $signed(CX_W'(b_reg) << SH);
    assign cz[0] = '0;

    generate
        for (genvar i = 0; i < CI; i++)
        begin : g_cordic
            if (i == CI - 1)
            begin : g_last
                vdb_cordic_cell #(.STEP(i)) u_cell (
                    .clk   (clk),
                    .x_in  (cx[i]),
                    .y_in  (cy[i]),
                    .z_in  (cz[i]),
                    .x_out (),
                    .y_out (),
                    .z_out (cz[i+1])
                );
            end
            else
            begin : g_mid
                vdb_cordic_cell #(.STEP(i)) u_cell (
                    .clk   (clk),
                    .x_in  (cx[i]),
                    .y_in  (cy[i]),
                    .z_in  (cz[i]),
                    .x_out (cx[i+1]),
                    .y_out (cy[i+1]),
                    .z_out (cz[i+1])
                );
            end
        end
    endgenerate

    // square root chain on dx^2 + dy^2
    assign sr_rad[0] = sum_reg;
    assign sr_rem[0] = '0;
    assign sr_q[0]   = '0;

    generate
        for (genvar j = 0; j < AW; j++)
        begin : g_sqrt
            if (j == AW - 1)
            begin : g_last
                vdb_sqrt_cell #(.AW(AW)) u_cell (
                    .clk     (clk),
                    .rad_in  (sr_rad[j]),
                    .rem_in  (sr_rem[j]),
                    .q_in    (sr_q[j]),
                    .rad_out (),
                    .rem_out (sr_rem[j+1]),
                    .q_out   (sr_q[j+1])
                );
            end
            else
            begin : g_mid
                vdb_sqrt_cell #(.AW(AW)) u_cell (
                    .clk     (clk),
                    .rad_in  (sr_rad[j]),
                    .rem_in  (sr_rem[j]),
                    .q_in    (sr_q[j]),
                    .rad_out (sr_rad[j+1]),
                    .rem_out (sr_rem[j+1]),
                    .q_out   (sr_q[j+1])
                );
            end
        end
    endgenerate

    // pad the angle chain to the common latency
    generate
        if (PC == 0)
        begin : g_zpad_none
            assign z_lat = cz[CI];
        end
        else
        begin : g_zpad
            logic signed [Z_W-1:0] zp_reg [0:PC-1];
            always_ff @(posedge clk)
            begin
                zp_reg[0] <= cz[CI];
                for (int k = 1; k < PC; k++)
                    zp_reg[k] <= zp_reg[k-1];
            end
            assign z_lat = zp_reg[PC-1];
        end
    endgenerate

    // pad the root chain to the common latency
    generate
        if (PS == 0)
        begin : g_spad_none
            assign q_lat = sr_q[AW];
            assign r_lat = sr_rem[AW];
        end
        else
        begin : g_spad
            logic [AW-1:0] qp_reg [0:PS-1];
            logic [RW-1:0] rp_reg [0:PS-1];
            always_ff @(posedge clk)
            begin
                qp_reg[0] <= sr_q[AW];
                rp_reg[0] <= sr_rem[AW];
                for (int k = 1; k < PS; k++)
                begin
                    qp_reg[k] <= qp_reg[k-1];
                    rp_reg[k] <= rp_reg[k-1];
                end
            end
            assign q_lat = qp_reg[PS-1];
            assign r_lat = rp_reg[PS-1];
        end
    endgenerate

    // valid bits beside the chains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                ln_v_reg[k] <= 1'b0;
        end
        else
        begin
            ln_v_reg[0] <= v2_reg;
            for (int k = 1; k < LAT; k++)
                ln_v_reg[k] <= ln_v_reg[k-1];
        end
    end

    // control beside the chains
    always_ff @(posedge clk)
    begin
        ln_ctl_reg[0] <= ctl_reg;
        for (int k = 1; k < LAT; k++)
            ln_ctl_reg[k] <= ln_ctl_reg[k-1];
    end

    // clamp the angle, fold to the left half, decide root rounding
    always_comb
    begin
        if (z_lat < 0)
            zc = '0;
        else if (z_lat > Z_90)
            zc = Z_90;
        else
            zc = z_lat;
        m_next  = ln_ctl_reg[LAT-1].dx_neg ? (Z_180 - 32'(zc)) : 32'(zc);
        up_next = ({2'b00, q_lat} < r_lat);
    end

    // round to the output angle unit and pick the special cases
    always_comb
    begin
        rnd       = 33'(m_reg) + HALF;
        mag       = BW'(rnd >> RS);
        dist_next = fq_reg + AW'(up_reg);
        unique case (fctl_reg.bc)
            BC_UP:     bear_next = B_UP;
            BC_DOWN:   bear_next = B_DOWN;
            BC_BACK:   bear_next = B_BACK;
            BC_ROTATE: bear_next = fctl_reg.dy_neg ? -mag : mag;
            default:   bear_next = mag;
        endcase
    end

    // fold and output valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fv_reg   <= ln_v_reg[LAT-1];
            done_reg <= fv_reg;
        end
    end

    // fold and output payload
    always_ff @(posedge clk)
    begin
        fctl_reg <= ln_ctl_reg[LAT-1];
        m_reg    <= m_next;
        up_reg   <= up_next;
        fq_reg   <= q_lat;
        dist_reg <= dist_next;
        bear_reg <= bear_next;
    end

    assign done     = done_reg;
    assign distance = dist_reg;
    assign bearing  = bear_reg;

endmodule
